// ===== design/bfca_pkg.sv =====
// Shared constants, codes and types for the best-fit cell allocator.
// No dependencies; every other design file except bfca_ram imports this package.
`timescale 1ns / 1ps
package bfca_pkg;

	localparam int CELLS  = 64;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CNT_W  = $clog2(CELLS + 1);
	localparam int CFG_W  = 7;
	localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int TAG_W  = 8;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;
	localparam int OUT_W  = 6;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);
	localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
	localparam logic [TAG_W-1:0] TAG_LAST  = TAG_W'(255);
	localparam logic [TAG_W-1:0] TAG_NONE  = '0;

	localparam logic [KIND_W-1:0] K_ALLOC  = 2'd0;
	localparam logic [KIND_W-1:0] K_FREE   = 2'd1;
	localparam logic [KIND_W-1:0] K_DEFRAG = 2'd2;
	localparam logic [KIND_W-1:0] K_RSVD   = 2'd3;

	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOTAG   = 2'd2;

	typedef struct packed {
		logic clr;
		logic step;
		logic is_free;
	} fit_ctl_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] start;
	} fit_res_t;

endpackage

// ===== design/bfca_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module bfca_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/bfca_map.sv =====
// Cell owner map: RAM plus one written flag per cell, so unwritten cells read free.
// Depends on bfca_pkg and bfca_ram.
`timescale 1ns / 1ps
module bfca_map (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [bfca_pkg::ADDR_W-1:0]  rd_addr,
	output logic [bfca_pkg::TAG_W-1:0]   rd_data,
	input  logic                         wr_en,
	input  logic [bfca_pkg::ADDR_W-1:0]  wr_addr,
	input  logic [bfca_pkg::TAG_W-1:0]   wr_data
);
	import bfca_pkg::*;

	logic [CELLS-1:0] vld_q;
	logic             vld_s1;
	logic [TAG_W-1:0] ram_rd;

	bfca_ram #(.W(TAG_W), .D(CELLS)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = vld_s1 ? ram_rd : TAG_NONE;

endmodule

// ===== design/bfca_fit.sv =====
// Best-fit run tracker: follows the free/owned stream of a scan and keeps the
// shortest adequate free run. Depends on bfca_pkg.
`timescale 1ns / 1ps
module bfca_fit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bfca_pkg::fit_ctl_t          ctl,
	input  logic [bfca_pkg::CFG_W-1:0]  size,
	input  logic [bfca_pkg::CNT_W-1:0]  idx,
	input  logic [bfca_pkg::CNT_W-1:0]  n,
	output bfca_pkg::fit_res_t          res
);
	import bfca_pkg::*;

	logic [CNT_W-1:0]  run_q;
	logic [CNT_W-1:0]  best_len_q;
	logic [ADDR_W-1:0] best_start_q;
	logic              found_q;
	logic              close_ok;

	assign close_ok = (run_q != '0) && (CMP_W'(run_q) >= CMP_W'(size))
		&& (!found_q || (run_q < best_len_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q        <= '0;
			best_len_q   <= '0;
			best_start_q <= '0;
			found_q      <= 1'b0;
		end else if (ctl.clr) begin
			run_q        <= '0;
			best_len_q   <= '0;
			best_start_q <= '0;
			found_q      <= 1'b0;
		end else if (ctl.step) begin
			if (ctl.is_free) begin
				run_q <= run_q + CNT_W'(1);
			end else begin
				if (close_ok) begin
					found_q      <= 1'b1;
					best_len_q   <= run_q;
					best_start_q <= ADDR_W'(idx - run_q);
				end
				run_q <= '0;
			end
		end
	end

	// close the trailing run at the end of the managed range
	assign res.found = found_q | close_ok;
	assign res.start = close_ok ? ADDR_W'(n - run_q) : best_start_q;

endmodule

// ===== design/best_fit_cell_allocator.sv =====
// Best-fit cell allocator top level: request sequencer, config register, result register.
// Depends on bfca_pkg, bfca_map and bfca_fit.
//
// Requests enter on in_valid/in_ready (kind, alloc_size, free_tag); one result
// per request leaves on out_valid/out_ready (status, start_cell, granted_tag).
// cells_in_use is written through cfg_wr_en/cfg_wr_data; the user must write it only
// while the block is idle, as the block itself does not enforce this. One request is
// in work at a time; in_ready is high only when the sequencer is idle. Each free,
// defragment or nonzero-size allocate request reads the whole managed map through
// the single RAM read port, one cell per cycle. An allocate then writes its granted
// cells; a defragment compacts the owned cells during the scan, then clears the rest
// of the range; a zero-size allocate or an unused kind goes straight to the result.
// The result sits in an output register; a new request is taken while it waits,
// and a later result holds in the sequencer until the receiver takes the old one.
// Reset empties the map at once (per-cell written flags), sets the next tag to 1
// and cells_in_use to 64; no clearing pass is needed.
`timescale 1ns / 1ps
module best_fit_cell_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [bfca_pkg::CFG_W-1:0]   cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bfca_pkg::KIND_W-1:0]  kind,
	input  logic [bfca_pkg::CFG_W-1:0]   alloc_size,
	input  logic [bfca_pkg::TAG_W-1:0]   free_tag,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bfca_pkg::STAT_W-1:0]  status,
	output logic [bfca_pkg::OUT_W-1:0]   start_cell,
	output logic [bfca_pkg::TAG_W-1:0]   granted_tag
);
	import bfca_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FILL, S_CLEAR, S_DONE} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  cells_in_use_q;
	logic [TAG_W-1:0]  next_tag_q;
	logic [KIND_W-1:0] kind_q;
	logic [CFG_W-1:0]  size_q;
	logic [TAG_W-1:0]  tag_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic [CNT_W-1:0]  wr_ptr_q;
	logic [CNT_W-1:0]  fill_last_q;
	logic              present_q;
	logic              rd_v_s1;
	logic [ADDR_W-1:0] rd_idx_s1;
	logic [STAT_W-1:0] res_status_q;
	logic [ADDR_W-1:0] res_start_q;
	logic [TAG_W-1:0]  res_tag_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [OUT_W-1:0]  start_cell_q;
	logic [TAG_W-1:0]  granted_tag_q;

	logic [CNT_W-1:0]  n_cells;
	logic              accept;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [TAG_W-1:0]  rd_data;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [TAG_W-1:0]  wr_data;
	logic              tag_hit;
	logic              scan_end;
	fit_ctl_t          fit_ctl;
	fit_res_t          fit_res;

	assign n_cells = (CMP_W'(cells_in_use_q) > CMP_W'(CELLS)) ? CNT_W'(CELLS)
		: CNT_W'(cells_in_use_q);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign rd_en    = (state_q == S_SCAN) && (rd_cnt_q < n_q);
	assign rd_addr  = rd_cnt_q[ADDR_W-1:0];
	assign tag_hit  = (tag_q != TAG_NONE) && (rd_data == tag_q);
	assign scan_end = (state_q == S_SCAN) && (rd_cnt_q == n_q) && !rd_v_s1;

	assign fit_ctl.clr     = accept;
	assign fit_ctl.step    = (state_q == S_SCAN) && rd_v_s1 && (kind_q == K_ALLOC);
	assign fit_ctl.is_free = (rd_data == TAG_NONE);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = TAG_NONE;
		case (state_q)
			S_SCAN: begin
				if (rd_v_s1 && (kind_q == K_FREE) && tag_hit) begin
					wr_en   = 1'b1;
					wr_addr = rd_idx_s1;
				end else if (rd_v_s1 && (kind_q == K_DEFRAG) && (rd_data != TAG_NONE)) begin
					wr_en   = 1'b1;
					wr_addr = wr_ptr_q[ADDR_W-1:0];
					wr_data = rd_data;
				end
			end
			S_FILL: begin
				wr_en   = 1'b1;
				wr_addr = wr_ptr_q[ADDR_W-1:0];
				wr_data = next_tag_q;
			end
			S_CLEAR: begin
				wr_en   = (wr_ptr_q < n_q);
				wr_addr = wr_ptr_q[ADDR_W-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	bfca_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	bfca_fit u_fit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fit_ctl),
		.size   (size_q),
		.idx    (CNT_W'(rd_idx_s1)),
		.n      (n_q),
		.res    (fit_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cells_in_use_q <= CFG_RESET;
			next_tag_q     <= TAG_FIRST;
			kind_q         <= K_ALLOC;
			size_q         <= '0;
			tag_q          <= TAG_NONE;
			n_q            <= '0;
			rd_cnt_q       <= '0;
			wr_ptr_q       <= '0;
			fill_last_q    <= '0;
			present_q      <= 1'b0;
			rd_v_s1        <= 1'b0;
			rd_idx_s1      <= '0;
			res_status_q   <= ST_DONE;
			res_start_q    <= '0;
			res_tag_q      <= TAG_NONE;
			out_valid_q    <= 1'b0;
			status_q       <= ST_DONE;
			start_cell_q   <= '0;
			granted_tag_q  <= TAG_NONE;
		end else begin
			if (cfg_wr_en) begin
				cells_in_use_q <= cfg_wr_data;
			end
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q       <= kind;
						size_q       <= alloc_size;
						tag_q        <= free_tag;
						n_q          <= n_cells;
						rd_cnt_q     <= '0;
						wr_ptr_q     <= '0;
						present_q    <= 1'b0;
						rd_v_s1      <= 1'b0;
						res_status_q <= ST_DONE;
						res_start_q  <= '0;
						res_tag_q    <= TAG_NONE;
						if (kind == K_RSVD) begin
							state_q <= S_DONE;
						end else if ((kind == K_ALLOC) && (alloc_size == '0)) begin
							res_status_q <= ST_NOSPACE;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					rd_v_s1 <= rd_en;
					if (rd_en) begin
						rd_cnt_q  <= rd_cnt_q + CNT_W'(1);
						rd_idx_s1 <= rd_addr;
					end
					if (rd_v_s1 && (kind_q == K_DEFRAG) && (rd_data != TAG_NONE)) begin
						wr_ptr_q <= wr_ptr_q + CNT_W'(1);
					end
					if (rd_v_s1 && (kind_q == K_FREE) && tag_hit) begin
						present_q <= 1'b1;
					end
					if (scan_end) begin
						case (kind_q)
							K_ALLOC: begin
								if (fit_res.found) begin
									wr_ptr_q    <= CNT_W'(fit_res.start);
									fill_last_q <= CNT_W'(fit_res.start) + CNT_W'(size_q)
										- CNT_W'(1);
									res_start_q <= fit_res.start;
									state_q     <= S_FILL;
								end else begin
									res_status_q <= ST_NOSPACE;
									state_q      <= S_DONE;
								end
							end
							K_FREE: begin
								res_status_q <= present_q ? ST_DONE : ST_NOTAG;
								state_q      <= S_DONE;
							end
							K_DEFRAG: begin
								state_q <= S_CLEAR;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_FILL: begin
					if (wr_ptr_q == fill_last_q) begin
						res_tag_q  <= next_tag_q;
						next_tag_q <= (next_tag_q == TAG_LAST) ? TAG_FIRST
							: next_tag_q + TAG_W'(1);
						state_q    <= S_DONE;
					end else begin
						wr_ptr_q <= wr_ptr_q + CNT_W'(1);
					end
				end
				S_CLEAR: begin
					if (wr_ptr_q < n_q) begin
						wr_ptr_q <= wr_ptr_q + CNT_W'(1);
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						status_q      <= res_status_q;
						start_cell_q  <= OUT_W'(res_start_q);
						granted_tag_q <= res_tag_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign start_cell  = start_cell_q;
	assign granted_tag = granted_tag_q;

endmodule

// ===== design/bfca_chk.sv =====
// Port-level checker for the best-fit cell allocator, bound to the top level.
// Depends on bfca_pkg and best_fit_cell_allocator.
`timescale 1ns / 1ps
module bfca_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [bfca_pkg::STAT_W-1:0]  status,
	input logic [bfca_pkg::OUT_W-1:0]   start_cell,
	input logic [bfca_pkg::TAG_W-1:0]   granted_tag
);
	import bfca_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(start_cell) && $stable(granted_tag))
		else $error("result changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_DONE) |-> (start_cell == '0) && (granted_tag == TAG_NONE))
		else $error("failed request carries a grant");

	a_nogrant_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (granted_tag == TAG_NONE) |-> (start_cell == '0))
		else $error("start cell without a granted tag");

	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in work");

	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared one cycle after a request");

endmodule

bind best_fit_cell_allocator bfca_chk u_chk (.*);

// ===== tb/best_fit_cell_allocator_tb.sv =====
// Self-checking testbench for best_fit_cell_allocator: directed and random requests
// across several cells_in_use settings, checked against an in-bench map predictor.
// Depends on bfca_pkg and the design files under design/.
`timescale 1ns / 1ps
module best_fit_cell_allocator_tb;
	import bfca_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int PHASES      = 11;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [CFG_W-1:0]  size;
		logic [TAG_W-1:0]  tag;
	} request_t;

	typedef struct {
		logic [STAT_W-1:0] status;
		logic [OUT_W-1:0]  start;
		logic [TAG_W-1:0]  tag;
	} grant_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0]   cfg_wr_data = CFG_RESET;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [KIND_W-1:0]  kind        = K_ALLOC;
	logic [CFG_W-1:0]   alloc_size  = '0;
	logic [TAG_W-1:0]   free_tag    = TAG_NONE;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [STAT_W-1:0]  status;
	logic [OUT_W-1:0]   start_cell;
	logic [TAG_W-1:0]   granted_tag;

	logic [TAG_W-1:0]   owner_map [CELLS] = '{default: TAG_NONE};
	logic [TAG_W-1:0]   tag_next    = TAG_FIRST;
	logic [CFG_W-1:0]   managed_cfg = CFG_RESET;

	request_t requests_waiting[$];
	grant_t   grants_due[$];

	bit req_took;
	bit tx_idle;
	bit rx_idle;
	int send_gap;
	int rx_stall;
	int quiet_cycles;
	int mismatches;
	int results_seen;

	int phase_cfg   [PHASES] = '{0, 1, 127, 2, -1, -1, -1, 16, -1, 64, 64};
	int phase_items [PHASES] = '{40, 80, 250, 60, 180, 180, 180, 180, 180, 200, 100};

	best_fit_cell_allocator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.alloc_size  (alloc_size),
		.free_tag    (free_tag),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.start_cell  (start_cell),
		.granted_tag (granted_tag)
	);

	always #1 clk = ~clk;

	function automatic int managed_count();
		return (managed_cfg > CELLS) ? CELLS : int'(managed_cfg);
	endfunction

	// apply one request to the cell map and queue the grant it should produce
	task automatic serve_request(input request_t rq);
		int n, run, best_len, best_start, w, i;
		bit found, open_cell, present;
		grant_t g;
		n = managed_count();
		g.status = ST_DONE;
		g.start = '0;
		g.tag = TAG_NONE;
		case (rq.kind)
			K_ALLOC: begin
				run = 0;
				best_len = 0;
				best_start = 0;
				found = 1'b0;
				for (i = 0; i <= n; i++) begin
					if (i < n)
						open_cell = (owner_map[i] == TAG_NONE);
					else
						open_cell = 1'b0;
					if (open_cell) begin
						run++;
					end else begin
						if (run != 0 && run >= rq.size && (!found || run < best_len)) begin
							found = 1'b1;
							best_len = run;
							best_start = i - run;
						end
						run = 0;
					end
				end
				if (rq.size != 0 && found) begin
					for (i = best_start; i < best_start + rq.size && i < n; i++)
						owner_map[i] = tag_next;
					g.start = best_start[OUT_W-1:0];
					g.tag = tag_next;
					tag_next = (tag_next == TAG_LAST) ? TAG_FIRST : tag_next + 1'b1;
				end else begin
					g.status = ST_NOSPACE;
				end
			end
			K_FREE: begin
				present = 1'b0;
				if (rq.tag != TAG_NONE) begin
					for (i = 0; i < n; i++) begin
						if (owner_map[i] == rq.tag) begin
							present = 1'b1;
							owner_map[i] = TAG_NONE;
						end
					end
				end
				if (!present)
					g.status = ST_NOTAG;
			end
			K_DEFRAG: begin
				w = 0;
				for (i = 0; i < n; i++) begin
					if (owner_map[i] != TAG_NONE) begin
						owner_map[w] = owner_map[i];
						w++;
					end
				end
				for (i = w; i < n; i++)
					owner_map[i] = TAG_NONE;
			end
			default: ;
		endcase
		grants_due.push_back(g);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on result %0d: %s got %0d expected %0d",
			results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic queue_request(input logic [KIND_W-1:0] k, input int size, input int tag);
		request_t rq;
		rq.kind = k;
		rq.size = size[CFG_W-1:0];
		rq.tag = tag[TAG_W-1:0];
		while (requests_waiting.size() >= 2)
			@(posedge clk);
		requests_waiting.push_back(rq);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (requests_waiting.size() != 0 || in_valid || grants_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cells(input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		managed_cfg = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly allocate/free traffic on recent tags, some defrag, a little noise
	task automatic queue_random_request();
		int n, pick, t;
		n = managed_count();
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			if (n == 0 || $urandom_range(0, 29) == 0)
				queue_request(K_ALLOC, $urandom_range(0, 127), $urandom_range(0, 255));
			else if ($urandom_range(0, 9) == 0)
				queue_request(K_ALLOC, $urandom_range(1, n), $urandom_range(0, 255));
			else
				queue_request(K_ALLOC, $urandom_range(1, (n / 3 > 1) ? n / 3 : 1),
					$urandom_range(0, 255));
		end else if (pick < 80) begin
			t = int'(tag_next) - int'($urandom_range(1, 12));
			if (t < 1)
				t += 255;
			if ($urandom_range(0, 19) == 0)
				t = $urandom_range(0, 255);
			queue_request(K_FREE, $urandom_range(0, 127), t);
		end else if (pick < 92) begin
			queue_request(K_DEFRAG, $urandom_range(0, 127), $urandom_range(0, 255));
		end else if (pick < 95) begin
			queue_request(K_RSVD, $urandom_range(0, 127), $urandom_range(0, 255));
		end else begin
			queue_request(KIND_W'($urandom_range(0, 3)), $urandom_range(0, 127),
				$urandom_range(0, 255));
		end
	endtask

	// request driver
	always @(negedge clk) begin
		request_t rq;
		bit slot_open;
		slot_open = !in_valid || req_took;
		req_took = 1'b0;
		if (slot_open && send_gap == 0 && tx_idle && $urandom_range(0, 5) == 0)
			send_gap = $urandom_range(1, 6);
		if (slot_open) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (arst_n && requests_waiting.size() != 0) begin
				rq = requests_waiting.pop_front();
				in_valid <= 1'b1;
				kind <= rq.kind;
				alloc_size <= rq.size;
				free_tag <= rq.tag;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (rx_stall == 0 && rx_idle && $urandom_range(0, 7) == 0)
			rx_stall = $urandom_range(1, 6);
		if (rx_stall > 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		grant_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				serve_request('{kind, alloc_size, free_tag});
				req_took = 1'b1;
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				if (grants_due.size() == 0) begin
					report_mismatch("result with nothing outstanding, status", status, 0);
				end else begin
					want = grants_due.pop_front();
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (start_cell !== want.start)
						report_mismatch("start_cell", start_cell, want.start);
					if (granted_tag !== want.tag)
						report_mismatch("granted_tag", granted_tag, want.tag);
				end
				results_seen++;
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		int p, j, v;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_cells(7'd64);

		queue_request(K_ALLOC, 0, 0);
		queue_request(K_ALLOC, 127, 255);
		queue_request(K_RSVD, 127, 255);
		queue_request(K_FREE, 0, 0);
		queue_request(K_FREE, 1, 255);
		queue_request(K_DEFRAG, 0, 0);
		queue_request(K_ALLOC, 64, 0);
		queue_request(K_ALLOC, 1, 0);
		queue_request(K_FREE, 0, 1);
		queue_request(K_ALLOC, 1, 0);
		queue_request(K_ALLOC, 3, 0);
		queue_request(K_ALLOC, 1, 0);
		queue_request(K_ALLOC, 2, 0);
		queue_request(K_ALLOC, 1, 0);
		queue_request(K_FREE, 0, 3);
		queue_request(K_FREE, 0, 5);
		queue_request(K_ALLOC, 1, 0);
		queue_request(K_ALLOC, 1, 0);
		queue_request(K_ALLOC, 2, 0);
		queue_request(K_FREE, 0, 4);
		queue_request(K_DEFRAG, 0, 0);
		queue_request(K_ALLOC, 60, 0);
		queue_request(K_ALLOC, 58, 0);
		queue_request(K_FREE, 0, 200);

		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			v = (phase_cfg[p] < 0) ? $urandom_range(3, 63) : phase_cfg[p];
			write_cells(v[CFG_W-1:0]);
			tx_idle = (p != PHASES - 1) && (p % 4 != 0);
			rx_idle = (p != PHASES - 1) && (p % 4 != 1);
			for (j = 0; j < phase_items[p]; j++)
				queue_random_request();
		end

		wait_drained();
		repeat (150) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
